// ===== hw/rtl/aes_pkg.sv =====
// Shared types, tables and round functions for the AES-128 CBC block.
package aes_pkg;

  localparam int NumRounds = 10;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        chain_start;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_beat_t;

  typedef logic [NumRounds:0][127:0] round_keys_t;

  typedef enum logic [2:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW  = 3'd1,
    REG_IV_HIGH  = 3'd2,
    REG_IV_LOW   = 3'd3,
    REG_DECRYPT  = 3'd4
  } reg_idx_t;

  localparam logic [0:255][7:0] SBOX = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [0:255][7:0] INV_SBOX = {
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // multiply by a 4-bit constant in GF(2^8)
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] a2, a4, a8;
    a2 = xt(a);
    a4 = xt(a2);
    a8 = xt(a4);
    gmul = (m[0] ? a : 8'h00) ^ (m[1] ? a2 : 8'h00) ^ (m[2] ? a4 : 8'h00) ^
           (m[3] ? a8 : 8'h00);
  endfunction

  // byte i of the state sits at bits 127-8i down
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      o[8*(15-i) +: 8] = inv ? INV_SBOX[s[8*(15-i) +: 8]] : SBOX[s[8*(15-i) +: 8]];
    end
    sub_bytes = o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    int src;
    o = s;
    for (int r = 1; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = inv ? (r + 4 * ((c - r + 4) % 4)) : (r + 4 * ((c + r) % 4));
        o[8*(15-(r+4*c)) +: 8] = s[8*(15-src) +: 8];
      end
    end
    shift_rows = o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [3:0][3:0] m;
    logic [7:0] v;
    m = inv ? {4'd9, 4'd13, 4'd11, 4'd14} : {4'd1, 4'd1, 4'd3, 4'd2};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) begin
          v = v ^ gmul(s[8*(15-(4*c+k)) +: 8], m[(k - r + 4) % 4]);
        end
        o[8*(15-(4*c+r)) +: 8] = v;
      end
    end
    mix_columns = o;
  endfunction

  function automatic round_keys_t expand_key(input logic [127:0] key);
    round_keys_t rk;
    logic [31:0] w0, w1, w2, w3, t;
    logic [7:0] rc;
    rk[0] = key;
    rc = 8'h01;
    for (int r = 1; r <= NumRounds; r++) begin
      {w0, w1, w2, w3} = rk[r-1];
      t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      rk[r] = {w0, w1, w2, w3};
      rc = xt(rc);
    end
    expand_key = rk;
  endfunction

endpackage

// ===== hw/rtl/aes128_cbc_cipher.sv =====
// AES-128 CBC top level: register file, input stage, cipher and result stage.
//
// One beat in, one beat out; a block enters the input register, passes the
// whole ten-round cipher combinationally and lands in the result register, so
// a new block is taken every cycle unless out_ready stalls the result register,
// and the result beat is registered after the input register. The round
// keys are expanded and stored in the cycle a key half is written. Write the
// key, IV and mode with the block idle; chain_start picks the IV, otherwise
// the previous ciphertext block is the chaining value.
module aes128_cbc_cipher (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  aes_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output aes_pkg::out_beat_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic        decrypt_r;
  logic [127:0] chain_r;
  logic        cfg_wr;
  aes_pkg::reg_idx_t cfg_idx;
  logic        key_wr;
  logic [127:0] key_nxt;
  aes_pkg::round_keys_t round_keys;

  aes_pkg::in_beat_t  in_r;
  logic               in_vld_r;
  aes_pkg::out_beat_t out_r;
  logic               out_vld_r;
  logic               advance;
  logic [127:0]       blk, chain_sel, result;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = aes_pkg::reg_idx_t'(paddr[5:3]);
  assign key_wr  = cfg_wr & (cfg_idx == aes_pkg::REG_KEY_HIGH ||
                             cfg_idx == aes_pkg::REG_KEY_LOW);
  assign key_nxt = {(cfg_idx == aes_pkg::REG_KEY_HIGH) ? pwdata : key_high_r,
                    (cfg_idx == aes_pkg::REG_KEY_LOW)  ? pwdata : key_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      iv_high_r  <= '0;
      iv_low_r   <= '0;
      decrypt_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        aes_pkg::REG_KEY_HIGH: key_high_r <= pwdata;
        aes_pkg::REG_KEY_LOW:  key_low_r  <= pwdata;
        aes_pkg::REG_IV_HIGH:  iv_high_r  <= pwdata;
        aes_pkg::REG_IV_LOW:   iv_low_r   <= pwdata;
        aes_pkg::REG_DECRYPT:  decrypt_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      aes_pkg::REG_KEY_HIGH: prdata = key_high_r;
      aes_pkg::REG_KEY_LOW:  prdata = key_low_r;
      aes_pkg::REG_IV_HIGH:  prdata = iv_high_r;
      aes_pkg::REG_IV_LOW:   prdata = iv_low_r;
      aes_pkg::REG_DECRYPT:  prdata = {63'd0, decrypt_r};
      default:               prdata = '0;
    endcase
  end

  aes_key_expand u_key_expand (
    .clk        (clk),
    .key_wr     (key_wr),
    .key        (key_nxt),
    .round_keys (round_keys)
  );

  assign advance  = in_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~in_vld_r | advance;

  assign blk       = {in_r.data_high, in_r.data_low};
  assign chain_sel = in_r.chain_start ? {iv_high_r, iv_low_r} : chain_r;

  aes_cipher u_cipher (
    .decrypt    (decrypt_r),
    .blk        (blk),
    .chain      (chain_sel),
    .round_keys (round_keys),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      chain_r   <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        chain_r   <= decrypt_r ? blk : result;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= {result[127:64], result[63:0]};
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/aes_key_expand.sv =====
// Round key expansion, registered when either key half is written.
module aes_key_expand (
  input  logic                 clk,
  input  logic                 key_wr,
  input  logic [127:0]         key,
  output aes_pkg::round_keys_t round_keys
);

  aes_pkg::round_keys_t rk_r;

  always_ff @(posedge clk) begin
    if (key_wr) begin
      rk_r <= aes_pkg::expand_key(key);
    end
  end

  assign round_keys = rk_r;

endmodule

// ===== hw/rtl/aes_cipher.sv =====
// Full AES-128 encipher/decipher with CBC XOR, single combinational pass.
module aes_cipher (
  input  logic                 decrypt,
  input  logic [127:0]         blk,
  input  logic [127:0]         chain,
  input  aes_pkg::round_keys_t round_keys,
  output logic [127:0]         result
);

  logic [127:0] enc_s, dec_s;

  always_comb begin
    enc_s = blk ^ chain ^ round_keys[0];
    for (int r = 1; r <= aes_pkg::NumRounds; r++) begin
      enc_s = aes_pkg::shift_rows(aes_pkg::sub_bytes(enc_s, 1'b0), 1'b0);
      if (r != aes_pkg::NumRounds) begin
        enc_s = aes_pkg::mix_columns(enc_s, 1'b0);
      end
      enc_s = enc_s ^ round_keys[r];
    end
  end

  always_comb begin
    dec_s = blk ^ round_keys[aes_pkg::NumRounds];
    for (int r = aes_pkg::NumRounds - 1; r >= 0; r--) begin
      dec_s = aes_pkg::sub_bytes(aes_pkg::shift_rows(dec_s, 1'b1), 1'b1) ^ round_keys[r];
      if (r != 0) begin
        dec_s = aes_pkg::mix_columns(dec_s, 1'b1);
      end
    end
  end

  assign result = decrypt ? (dec_s ^ chain) : enc_s;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the AES-128 CBC block: directed table, then random messages.
module tb;

  typedef enum logic {ROW_BLOCK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    aes_pkg::reg_idx_t  idx;
    logic [63:0]        wval;
    aes_pkg::in_beat_t  beat;
    bit                 typed;
    aes_pkg::out_beat_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  aes_pkg::in_beat_t in_data;
  aes_pkg::out_beat_t out_data;
  logic psel, penable, pwrite, pready;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;

  aes128_cbc_cipher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [7:0] fwd_sb [256];
  logic [7:0] inv_sb [256];
  logic [127:0] sched [11];
  logic [63:0] key_h, key_l, iv_h, iv_l;
  logic mode_dec;
  logic [127:0] chain_val;
  aes_pkg::out_beat_t pending_q[$];
  stim_row_t rows[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;

  function automatic logic [7:0] ff_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic void build_sboxes();
    logic [7:0] v, s;
    for (int x = 0; x < 256; x++) begin
      v = 8'h00;
      if (x != 0) begin
        v = 8'h01;
        for (int k = 0; k < 254; k++) v = ff_mul(v, x[7:0]);
      end
      s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]} ^ 8'h63;
      fwd_sb[x] = s;
      inv_sb[s] = x[7:0];
    end
  endfunction

  function automatic logic [7:0] byte_at(logic [127:0] s, int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] subst(logic [127:0] s, bit inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++)
      o[127-8*i -: 8] = inv ? inv_sb[byte_at(s, i)] : fwd_sb[byte_at(s, i)];
    return o;
  endfunction

  function automatic logic [127:0] rotate_rows(logic [127:0] s, bit inv);
    logic [127:0] o;
    int c2;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        c2 = inv ? (c + 4 - r) % 4 : (c + r) % 4;
        o[127-8*(r+4*c) -: 8] = byte_at(s, r + 4*c2);
      end
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(logic [127:0] s, bit inv);
    logic [127:0] o;
    logic [7:0] coef [4];
    logic [7:0] acc;
    if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= ff_mul(coef[(k + 4 - r) % 4], byte_at(s, 4*c + k));
        o[127-8*(4*c+r) -: 8] = acc;
      end
    return o;
  endfunction

  function automatic void build_schedule();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0] rcon;
    logic [127:0] kw;
    rcon = 8'h01;
    kw = {key_h, key_l};
    for (int i = 0; i < 4; i++) w[i] = kw[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {fwd_sb[t[23:16]] ^ rcon, fwd_sb[t[15:8]], fwd_sb[t[7:0]], fwd_sb[t[31:24]]};
        rcon = ff_mul(rcon, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] encrypt_block(logic [127:0] s);
    s ^= sched[0];
    for (int r = 1; r <= 10; r++) begin
      s = rotate_rows(subst(s, 0), 0);
      if (r != 10) s = mix_cols(s, 0);
      s ^= sched[r];
    end
    return s;
  endfunction

  function automatic logic [127:0] decrypt_block(logic [127:0] s);
    s ^= sched[10];
    for (int r = 9; r >= 0; r--) begin
      s = subst(rotate_rows(s, 1), 1);
      s ^= sched[r];
      if (r != 0) s = mix_cols(s, 1);
    end
    return s;
  endfunction

  function automatic aes_pkg::out_beat_t cbc_next(aes_pkg::in_beat_t b);
    logic [127:0] cv, d, r;
    cv = b.chain_start ? {iv_h, iv_l} : chain_val;
    d = {b.data_high, b.data_low};
    if (mode_dec) begin
      r = decrypt_block(d) ^ cv;
      chain_val = d;
    end else begin
      r = encrypt_block(d ^ cv);
      chain_val = r;
    end
    return '{result_high: r[127:64], result_low: r[63:0]};
  endfunction

  function automatic void model_write(aes_pkg::reg_idx_t idx, logic [63:0] v);
    case (idx)
      aes_pkg::REG_KEY_HIGH: begin
        key_h = v;
        build_schedule();
      end
      aes_pkg::REG_KEY_LOW: begin
        key_l = v;
        build_schedule();
      end
      aes_pkg::REG_IV_HIGH: iv_h = v;
      aes_pkg::REG_IV_LOW: iv_l = v;
      aes_pkg::REG_DECRYPT: mode_dec = v[0];
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(aes_pkg::reg_idx_t idx, logic [63:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    model_write(idx, v);
    @(posedge clk);
  endtask

  task automatic send_block(aes_pkg::in_beat_t b, bit typed, aes_pkg::out_beat_t want);
    aes_pkg::out_beat_t got;
    int gap;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    got = cbc_next(b);
    pending_q.push_back(typed ? want : got);
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    aes_pkg::out_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result beat %h", out_data);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_data.result_high !== e.result_high) begin
          $error("result_high: expected %h, got %h", e.result_high, out_data.result_high);
          errors++;
        end
        if (out_data.result_low !== e.result_low) begin
          $error("result_low: expected %h, got %h", e.result_low, out_data.result_low);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic void add_write(aes_pkg::reg_idx_t idx, logic [63:0] v);
    stim_row_t r;
    r = '{kind: ROW_WRITE, idx: idx, wval: v, beat: '0, typed: 0, want: '0};
    rows.push_back(r);
  endfunction

  function automatic void add_block(logic [63:0] h, logic [63:0] l, bit cs, bit typed,
                                    logic [63:0] eh, logic [63:0] el);
    stim_row_t r;
    r = '{kind: ROW_BLOCK, idx: aes_pkg::REG_KEY_HIGH, wval: '0,
          beat: '{data_high: h, data_low: l, chain_start: cs}, typed: typed,
          want: '{result_high: eh, result_low: el}};
    rows.push_back(r);
  endfunction

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    aes_pkg::in_beat_t b;
    int pct [4][2];
    pct = '{'{0, 0}, '{81, 0}, '{0, 81}, '{28, 28}};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    build_sboxes();
    key_h = '0;
    key_l = '0;
    iv_h = '0;
    iv_l = '0;
    mode_dec = 1'b0;
    chain_val = '0;
    build_schedule();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_write(aes_pkg::REG_KEY_HIGH, 64'h0001020304050607);
    add_write(aes_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    add_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1, 1,
              64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    add_block('0, '0, 0, 0, '0, '0);
    add_block('1, '1, 1, 0, '0, '0);
    add_write(aes_pkg::REG_IV_HIGH, '1);
    add_write(aes_pkg::REG_IV_LOW, '1);
    add_block('1, '1, 1, 0, '0, '0);
    add_block(64'h8000000000000001, 64'h0123456789abcdef, 0, 0, '0, '0);
    add_write(aes_pkg::REG_DECRYPT, 64'd1);
    add_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1, 1,
              64'hffeeddccbbaa9988, 64'h7766554433221100);
    add_block('0, '0, 0, 0, '0, '0);
    add_block('1, '1, 0, 0, '0, '0);
    add_write(aes_pkg::reg_idx_t'(3'd5), '1);
    add_write(aes_pkg::reg_idx_t'(3'd7), '1);
    add_block('1, '0, 0, 0, '0, '0);
    add_write(aes_pkg::REG_KEY_LOW, '0);
    add_block(64'hfedcba9876543210, '1, 1, 0, '0, '0);
    add_write(aes_pkg::REG_DECRYPT, '0);
    add_block('0, '1, 0, 0, '0, '0);
    add_write(aes_pkg::REG_KEY_HIGH, '0);
    add_write(aes_pkg::REG_IV_HIGH, '0);
    add_write(aes_pkg::REG_IV_LOW, '0);
    add_block('0, '0, 1, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e);
    add_write(aes_pkg::REG_KEY_HIGH, '1);
    add_write(aes_pkg::REG_KEY_LOW, '1);
    add_block('1, '1, 1, 0, '0, '0);

    send_idle = 28;
    recv_stall = 28;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        wait_drained();
        reg_write(rows[i].idx, rows[i].wval);
      end else begin
        send_block(rows[i].beat, rows[i].typed, rows[i].want);
      end
    end

    for (int p = 0; p < 4; p++) begin
      send_idle = pct[p][0];
      recv_stall = pct[p][1];
      for (int g = 0; g < 6; g++) begin
        wait_drained();
        if ($urandom_range(1)) reg_write(aes_pkg::REG_KEY_HIGH, rand_word());
        if ($urandom_range(1)) reg_write(aes_pkg::REG_KEY_LOW, rand_word());
        if ($urandom_range(1)) reg_write(aes_pkg::REG_IV_HIGH, rand_word());
        if ($urandom_range(1)) reg_write(aes_pkg::REG_IV_LOW, rand_word());
        if ($urandom_range(3) == 0) begin
          reg_write(aes_pkg::reg_idx_t'($urandom_range(5, 7)), rand_word());
        end
        reg_write(aes_pkg::REG_DECRYPT, {$urandom, $urandom});
        for (int n = 0; n < 30; n++) begin
          b.data_high = rand_word();
          b.data_low = rand_word();
          b.chain_start = (n == 0) ? ($urandom_range(7) != 0) : ($urandom_range(7) == 0);
          send_block(b, 0, '0);
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/aes_pkg.sv
hw/rtl/aes_key_expand.sv
hw/rtl/aes_cipher.sv
hw/rtl/aes128_cbc_cipher.sv
dv/tb.sv
